@@ hw/rtl/lir_pkg.sv @@
// ----------------------------------------------------------------------------
// lir_pkg: shared types and constants for the linear interpolation resampler
// Request payload types, configuration port layout and fixed limits.
// ----------------------------------------------------------------------------
`default_nettype none

package lir_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int STEP_REG_BITS = 21;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = 1;
  localparam int CNT_BITS      = 6;

  localparam logic [STEP_REG_BITS-1:0] STEP_RESET     = 21'd65536;
  localparam logic [REG_IDX_BITS-1:0]  REG_PHASE_STEP = 1'b0;
  localparam logic [CNT_BITS-1:0]      MAX_RESULTS    = 6'd34;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          is_last;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          run_last;
    logic                          stream_end;
  } out_t;

endpackage

`default_nettype wire

@@ hw/rtl/lir_cfg.sv @@
// ----------------------------------------------------------------------------
// lir_cfg: configuration register file
// Holds the phase step register behind the APB port and supplies the step
// saturated to the supported range.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_cfg #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lir_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [lir_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [lir_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                   pready,
  output logic      [FRAC_BITS+4:0]              step_o
);
  import lir_pkg::*;

  localparam int          STEP_W  = FRAC_BITS + 5;
  localparam logic [31:0] StepMin = 32'd1 << (FRAC_BITS - 4);
  localparam logic [31:0] StepMax = 32'd16 << FRAC_BITS;

  logic [STEP_REG_BITS-1:0] phase_step_q;
  logic [REG_IDX_BITS-1:0]  reg_idx;
  logic [31:0]              raw_step;
  logic [31:0]              sat_step;

  assign reg_idx = paddr[APB_ADDR_BITS-1 -: REG_IDX_BITS];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= STEP_RESET;
    end else if (psel && penable && pwrite && reg_idx == REG_PHASE_STEP) begin
      phase_step_q <= pwdata[STEP_REG_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (psel && reg_idx == REG_PHASE_STEP) begin
      prdata = APB_DATA_BITS'(phase_step_q);
    end
  end

  always_comb begin
    raw_step = 32'(phase_step_q);
    if (raw_step < StepMin) begin
      sat_step = StepMin;
    end else if (raw_step > StepMax) begin
      sat_step = StepMax;
    end else begin
      sat_step = raw_step;
    end
  end

  assign step_o = sat_step[STEP_W-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/lir_lerp.sv @@
// ----------------------------------------------------------------------------
// lir_lerp: shared interpolation unit
// Two-stage multiply then round-and-add, giving a + (b - a) * frac or b.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_lerp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   mul_en_i,
  input  wire logic                                   add_en_i,
  input  wire logic                                   interp_i,
  input  wire logic signed [lir_pkg::SAMPLE_BITS-1:0] a_i,
  input  wire logic signed [lir_pkg::SAMPLE_BITS-1:0] b_i,
  input  wire logic        [FRAC_BITS-1:0]            frac_i,
  output logic signed      [lir_pkg::SAMPLE_BITS-1:0] res_o
);
  import lir_pkg::*;

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam logic signed [PROD_W-1:0] Half = PROD_W'(1) <<< (FRAC_BITS - 1);

  logic signed [DIFF_W-1:0]      diff;
  logic signed [FRAC_BITS:0]     frac_s;
  logic signed [PROD_W-1:0]      prod_d;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [SAMPLE_BITS-1:0] a_q;
  logic signed [SAMPLE_BITS-1:0] b_q;
  logic                          interp_q;
  logic signed [PROD_W-1:0]      shifted;
  logic signed [PROD_W-1:0]      sum;
  logic signed [SAMPLE_BITS-1:0] res_d;
  logic signed [SAMPLE_BITS-1:0] res_q;

  assign diff   = DIFF_W'(b_i) - DIFF_W'(a_i);
  assign frac_s = {1'b0, frac_i};
  assign prod_d = diff * frac_s;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q   <= prod_d;
      a_q      <= a_i;
      b_q      <= b_i;
      interp_q <= interp_i;
    end
  end

  assign shifted = (prod_q + Half) >>> FRAC_BITS;
  assign sum     = shifted + PROD_W'(a_q);
  assign res_d   = interp_q ? sum[SAMPLE_BITS-1:0] : b_q;

  always_ff @(posedge clk_i) begin
    if (add_en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/linear_interp_resampler.sv @@
// ----------------------------------------------------------------------------
// linear_interp_resampler: one-channel linear interpolation rate converter
// Top level: request sequencer, stream state, config port and lerp unit.
// ----------------------------------------------------------------------------
// Each accepted sample is held while the sequencer walks the output positions
// that fall before it, one at a time: ST_EVAL tests the position against the
// segment and clip limit and loads the product register of the shared
// multiplier, ST_MUL rounds and adds the result into the output register, then
// the result waits there in ST_OUT until taken.
// The block takes no new sample until the last result of the current one is
// taken. Write phase_step only while the block is idle.
`default_nettype none

module linear_interp_resampler #(
  parameter int FRAC_BITS  = 16,
  parameter int INDEX_BITS = 24
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire lir_pkg::in_t                      in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output lir_pkg::out_t                          out_data_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lir_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [lir_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [lir_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                   pready
);
  import lir_pkg::*;

  localparam int STEP_W = FRAC_BITS + 5;
  localparam int POS_W  = INDEX_BITS + FRAC_BITS;
  localparam int TEST_W = POS_W + 1;
  localparam int LIM_W  = POS_W + 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                    state_q;
  logic [1:0]                    state_d;
  logic [STEP_W-1:0]             step;
  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic signed [SAMPLE_BITS-1:0] cur_q;
  logic                          last_q;
  logic                          have_prev_q;
  logic                          emitted_q;
  logic [POS_W-1:0]              pos_q;
  logic [INDEX_BITS-1:0]         idx_q;
  logic [CNT_BITS-1:0]           cnt_q;
  logic                          more_q;
  logic signed [SAMPLE_BITS-1:0] lerp_res;

  logic [INDEX_BITS-1:0] prev_idx;
  logic                  in_seg;
  logic [TEST_W-1:0]     test_pos;
  logic [INDEX_BITS:0]   idx_inc;
  logic [LIM_W-1:0]      limit;
  logic                  counted;
  logic                  go;
  logic                  in_fire;
  logic                  out_fire;
  logic                  finish;
  logic                  mul_en;
  logic                  add_en;

  lir_cfg #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .step_o (step)
  );

  lir_lerp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_lerp (
    .clk_i   (clk_i),
    .mul_en_i(mul_en),
    .add_en_i(add_en),
    .interp_i(in_seg),
    .a_i     (prev_q),
    .b_i     (cur_q),
    .frac_i  (pos_q[FRAC_BITS-1:0]),
    .res_o   (lerp_res)
  );

  assign prev_idx = idx_q - INDEX_BITS'(1);
  assign in_seg   = have_prev_q && (pos_q[POS_W-1:FRAC_BITS] == prev_idx);
  assign test_pos = {pos_q, 1'b0} + TEST_W'(step);
  assign idx_inc  = (INDEX_BITS + 1)'(idx_q) + (INDEX_BITS + 1)'(1);
  assign limit    = {idx_inc, {(FRAC_BITS + 1){1'b0}}};
  assign counted  = {1'b0, test_pos} <= limit;
  assign go       = (cnt_q < MAX_RESULTS) &&
                    (last_q ? (counted || (cnt_q == '0 && !emitted_q)) : in_seg);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;
  assign mul_en      = (state_q == ST_EVAL) && go;
  assign add_en      = (state_q == ST_MUL);
  assign finish      = ((state_q == ST_EVAL) && !go) || (out_fire && !more_q);

  assign out_data_o.sample_out = lerp_res;
  assign out_data_o.run_last   = !more_q;
  assign out_data_o.stream_end = last_q && !more_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = go ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_fire) begin
          state_d = more_q ? ST_EVAL : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cur_q  <= in_data_i.sample_in;
      last_q <= in_data_i.is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      emitted_q   <= 1'b0;
      pos_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      more_q      <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_q <= '0;
      end
      if (mul_en) begin
        pos_q     <= pos_q + POS_W'(step);
        cnt_q     <= cnt_q + CNT_BITS'(1);
        emitted_q <= 1'b1;
      end
      if (add_en) begin
        more_q <= go;
      end
      if (finish) begin
        if (last_q) begin
          prev_q      <= '0;
          have_prev_q <= 1'b0;
          emitted_q   <= 1'b0;
          pos_q       <= '0;
          idx_q       <= '0;
        end else begin
          prev_q      <= cur_q;
          have_prev_q <= 1'b1;
          idx_q       <= idx_q + INDEX_BITS'(1);
        end
      end
    end
  end

  a_result_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_RESULTS)
    else $error("result count beyond limit");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("ready while a request is in work");

  a_more_stays_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !out_data_o.run_last) |=> (!in_ready_o && !out_valid_o))
    else $error("run ended before last result");

  a_last_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_data_o.run_last) |=> in_ready_o)
    else $error("not ready after last result");

  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.stream_end) |-> (out_data_o.run_last && last_q))
    else $error("stream end without run end");

endmodule

`default_nettype wire
